// File: design/tlv_attribute_list_checker_core_macros.svh
// Assertion macros for the attribute list checker.
`ifndef TLV_ATTRIBUTE_LIST_CHECKER_CORE_MACROS_SVH
`define TLV_ATTRIBUTE_LIST_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TLVALC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TLVALC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TLVALC_ASSERT_SAME(lbl, ante, cons)
`define TLVALC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/tlvalc_pkg.sv
`timescale 1ns / 1ps

package tlvalc_pkg;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 64;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CSR_W-1:0]   csr_data_type;
   typedef logic [ADDR_W-1:0]  csr_addr_type;

   localparam logic REG_WANTED_KEY = 1'b0;
   localparam byte_type WANTED_KEY_RESET = 8'd1;

endpackage

// File: design/tlvalc_if.sv
`timescale 1ns / 1ps

interface tlvalc_req_if;
   import tlvalc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type list_byte;
   logic     is_last;

   modport source (output valid, output list_byte, output is_last, input ready);
   modport sink (input valid, input list_byte, input is_last, output ready);
endinterface

interface tlvalc_rsp_if;
   import tlvalc_pkg::*;

   logic      valid;
   logic      ready;
   logic      list_valid;
   logic      attr_found;
   logic      value_ok;
   value_type attr_value;
   byte_type  value_len;

   modport source (output valid, output list_valid, output attr_found, output value_ok,
                   output attr_value, output value_len, input ready);
   modport sink (input valid, input list_valid, input attr_found, input value_ok,
                 input attr_value, input value_len, output ready);
endinterface

// File: design/tlv_attribute_list_checker_core.sv
`timescale 1ns / 1ps
// Attribute list checker.
// The req_chan channel carries one list byte per transaction, with is_last
// set on the final byte of the list buffer. Each list is key, size and value
// bytes repeated, ended by a zero key followed by zero padding.
// The rsp_chan channel carries one result transaction per list: validity,
// whether the configured key was found, its little-endian value and size.
// The register wanted_key sits at byte address 0 of the csr_ APB port; the
// user must write it only while no list is in progress (the block does not enforce this).
// Throughput is one byte per cycle, but a last byte waits while the result
// register is full. A byte is held in an input register; as it leaves, the
// parse state is updated from it, or on the last byte the result register is
// loaded and the parse state cleared, so a result passes through both registers.
// While the receiver stalls, the held result stays on rsp_chan and non-last
// bytes keep flowing; a last byte waits in the input register until the
// result register is free, and req_chan.ready then drops.
// Reset clears the parse state, empties both registers and sets wanted_key
// to one.

module tlv_attribute_list_checker_core #(
   parameter int VALUE_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   tlvalc_req_if.sink             req_chan,
   tlvalc_rsp_if.source           rsp_chan,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  tlvalc_pkg::csr_addr_type csr_paddr,
   input  tlvalc_pkg::csr_data_type csr_pwdata,
   output tlvalc_pkg::csr_data_type csr_prdata,
   output logic                   csr_pready
);
   import tlvalc_pkg::*;

   `include "tlv_attribute_list_checker_core_macros.svh"

   typedef enum logic [1:0] {PH_KEY, PH_SIZE, PH_VALUE, PH_PAD} phase_type;

   localparam int ACC_W = 8 * VALUE_BYTES;

   byte_type  wanted_key_ff;
   logic      s1_valid_ff;
   byte_type  s1_byte_ff;
   logic      s1_last_ff;
   logic      s1_adv;
   logic      rsp_free;

   phase_type        phase_ff, phase_in;
   byte_type         due_ff, due_in;
   logic [1:0]       count_ff, count_in;
   logic             bad_ff, bad_in;
   logic             done_ff, done_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   byte_type         flen_ff, flen_in;
   byte_type         idx;

   logic      truncated;
   logic      res_valid, res_ok;
   value_type res_value;
   byte_type  res_len;

   logic      rsp_valid_ff;
   logic      rsp_list_valid_ff, rsp_found_ff, rsp_ok_ff;
   value_type rsp_value_ff;
   byte_type  rsp_len_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WANTED_KEY) ? CSR_W'(wanted_key_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_key_ff <= WANTED_KEY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_WANTED_KEY) begin
         wanted_key_ff <= csr_pwdata[BYTE_W-1:0];
      end
   end

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.list_byte;
         s1_last_ff <= req_chan.is_last;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      due_in   = due_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      done_in  = done_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      acc_in   = acc_ff;
      flen_in  = flen_ff;
      idx      = flen_ff - due_ff;
      if (count_ff != 2'd2) begin
         count_in = count_ff + 2'd1;
      end
      case (phase_ff)
         PH_KEY: begin
            if (s1_byte_ff == '0) begin
               phase_in = PH_PAD;
               done_in  = 1'b1;
            end else begin
               phase_in = PH_SIZE;
               if (!done_ff && s1_byte_ff == wanted_key_ff) begin
                  pend_in = 1'b1;
               end
            end
         end
         PH_SIZE: begin
            due_in = s1_byte_ff;
            if (pend_ff) begin
               flen_in = s1_byte_ff;
               acc_in  = '0;
            end
            if (s1_byte_ff == '0) begin
               phase_in = PH_KEY;
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  found_in = 1'b1;
                  done_in  = 1'b1;
               end
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            for (int i = 0; i < VALUE_BYTES; i++) begin
               if (pend_ff && idx == 8'(i)) begin
                  acc_in[8*i +: 8] = s1_byte_ff;
               end
            end
            due_in = due_ff - 8'd1;
            if (due_in == '0) begin
               phase_in = PH_KEY;
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  found_in = 1'b1;
                  done_in  = 1'b1;
               end
            end
         end
         default: begin
            if (s1_byte_ff != '0) begin
               bad_in = 1'b1;
            end
         end
      endcase

      truncated = (phase_in == PH_SIZE) || (phase_in == PH_VALUE && due_in != '0);
      res_valid = !bad_in && !truncated && count_in == 2'd2;
      res_ok    = found_in && flen_in <= 8'(VALUE_BYTES);
      res_value = res_ok ? VALUE_W'(acc_in) : '0;
      res_len   = found_in ? flen_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_adv && s1_last_ff)) begin
         phase_ff <= PH_KEY;
         due_ff   <= '0;
         count_ff <= '0;
         bad_ff   <= 1'b0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         acc_ff   <= '0;
         flen_ff  <= '0;
      end else if (s1_adv) begin
         phase_ff <= phase_in;
         due_ff   <= due_in;
         count_ff <= count_in;
         bad_ff   <= bad_in;
         done_ff  <= done_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         acc_ff   <= acc_in;
         flen_ff  <= flen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv && s1_last_ff) begin
         rsp_list_valid_ff <= res_valid;
         rsp_found_ff      <= found_in;
         rsp_ok_ff         <= res_ok;
         rsp_value_ff      <= res_value;
         rsp_len_ff        <= res_len;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.list_valid = rsp_list_valid_ff;
   assign rsp_chan.attr_found = rsp_found_ff;
   assign rsp_chan.value_ok   = rsp_ok_ff;
   assign rsp_chan.attr_value = rsp_value_ff;
   assign rsp_chan.value_len  = rsp_len_ff;

   `TLVALC_ASSERT_SAME(a_not_found_zero, rsp_valid_ff && !rsp_found_ff, !rsp_ok_ff && rsp_len_ff == '0 && rsp_value_ff == '0)
   `TLVALC_ASSERT_SAME(a_ok_fits, rsp_valid_ff && rsp_ok_ff, rsp_found_ff && rsp_len_ff <= 8'(VALUE_BYTES))
   `TLVALC_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_ff, phase_ff == PH_KEY && count_ff == '0 && !found_ff && !pend_ff)
   `TLVALC_ASSERT_SAME(a_rsp_from_last, rsp_valid_ff && !$past(rsp_valid_ff), $past(s1_adv && s1_last_ff))
   `TLVALC_ASSERT_SAME(a_pend_excl_found, pend_ff, !found_ff && !done_ff)

endmodule

// File: bench/tlv_attribute_list_checker_core_test.sv
`timescale 1ns / 1ps

module tlv_attribute_list_checker_core_test;
   import tlvalc_pkg::*;

   localparam int VALUE_BYTES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 100;
   localparam int PHASE_LISTS = 2;
   localparam int PHASE_COUNT = 6;

   typedef enum logic [1:0] {AT_KEY, AT_SIZE, AT_VALUE, AT_PAD} parse_stage_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic      list_valid;
      logic      attr_found;
      logic      value_ok;
      value_type attr_value;
      byte_type  value_len;
   } list_verdict_type;

   class attr_list_scoreboard;
      byte_type         search_key;
      parse_stage_type  stage;
      byte_type         due;
      int unsigned      seen;
      bit               bad;
      bit               search_over;
      bit               matching;
      bit               found;
      value_type        acc;
      byte_type         found_size;
      list_verdict_type verdicts[$];
      int unsigned      errors;

      function new();
         search_key = WANTED_KEY_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         stage = AT_KEY;
         due = '0;
         seen = 0;
         bad = 1'b0;
         search_over = 1'b0;
         matching = 1'b0;
         found = 1'b0;
         acc = '0;
         found_size = '0;
      endfunction

      function void close_match();
         if (matching) begin
            matching = 1'b0;
            found = 1'b1;
            search_over = 1'b1;
         end
      endfunction

      function void note_byte(byte_type b, logic last);
         byte_type         idx;
         list_verdict_type v;
         if (seen < 2) seen++;
         case (stage)
            AT_KEY: begin
               if (b == 8'd0) begin
                  stage = AT_PAD;
                  search_over = 1'b1;
               end else begin
                  stage = AT_SIZE;
                  if (!search_over && b == search_key) matching = 1'b1;
               end
            end
            AT_SIZE: begin
               due = b;
               if (matching) begin
                  found_size = b;
                  acc = '0;
               end
               if (b == 8'd0) begin
                  stage = AT_KEY;
                  close_match();
               end else begin
                  stage = AT_VALUE;
               end
            end
            AT_VALUE: begin
               if (matching) begin
                  idx = found_size - due;
                  if (idx < VALUE_BYTES) acc |= value_type'(b) << (8 * idx);
               end
               due = due - 8'd1;
               if (due == 8'd0) begin
                  stage = AT_KEY;
                  close_match();
               end
            end
            default: begin
               if (b != 8'd0) bad = 1'b1;
            end
         endcase
         if (!last) return;
         v.list_valid = !bad && stage != AT_SIZE && !(stage == AT_VALUE && due != 0) && seen >= 2;
         v.attr_found = found;
         v.value_ok = found && found_size <= VALUE_BYTES;
         v.attr_value = v.value_ok ? acc : '0;
         v.value_len = found ? found_size : '0;
         verdicts.push_back(v);
         restart();
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(list_verdict_type got);
         list_verdict_type want;
         if (verdicts.size() == 0) begin
            $display("%0t: result transaction with none expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = verdicts.pop_front();
         compare_field("list_valid", 64'(want.list_valid), 64'(got.list_valid));
         compare_field("attr_found", 64'(want.attr_found), 64'(got.attr_found));
         compare_field("value_ok", 64'(want.value_ok), 64'(got.value_ok));
         compare_field("attr_value", want.attr_value, got.attr_value);
         compare_field("value_len", 64'(want.value_len), 64'(got.value_len));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic         csr_pready;

   tlvalc_req_if req_chan();
   tlvalc_rsp_if rsp_chan();

   attr_list_scoreboard tracker = new();
   idle_mode_type       idle_mode = IDLE_NONE;
   bit                  hold_request = 1'b0;
   int unsigned         cycle_count = 0;
   byte_type            list_bytes[$];

   tlv_attribute_list_checker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic send_byte(byte_type b, logic last);
      int unsigned pct;
      pct = (idle_mode == IDLE_SENDER) ? 66 : (idle_mode == IDLE_BOTH) ? 15 : 0;
      while ($urandom_range(99) < pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.list_byte = b;
      req_chan.is_last = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_list();
      foreach (list_bytes[i]) send_byte(list_bytes[i], i == list_bytes.size() - 1);
   endtask

   // A byte that produces no result can still be in flight once the queue
   // empties, so the block is not treated as idle as soon as the queue is empty.
   task automatic settle();
      req_chan.valid = 1'b0;
      while (tracker.verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_wanted_key(byte_type key);
      settle();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = csr_addr_type'(4 * REG_WANTED_KEY);
      csr_pwdata = csr_data_type'(key);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.search_key = key;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Mostly well-formed lists with random keys, sizes and values; a share of
   // them is cut short or gets a nonzero byte appended, and a few are noise.
   task automatic send_random_list();
      int unsigned shape;
      int unsigned attrs;
      int unsigned size;
      int unsigned pick;
      byte_type    key;
      list_bytes = {};
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 12)) list_bytes.push_back(byte_type'($urandom));
      end else begin
         attrs = $urandom_range(0, 4);
         repeat (attrs) begin
            if (tracker.search_key != 8'd0 && $urandom_range(99) < 40) key = tracker.search_key;
            else key = byte_type'($urandom_range(1, 255));
            pick = $urandom_range(99);
            if (pick < 70) size = $urandom_range(0, 8);
            else if (pick < 92) size = $urandom_range(9, 16);
            else if (pick < 98) size = $urandom_range(17, 40);
            else size = $urandom_range(128, 255);
            list_bytes.push_back(key);
            list_bytes.push_back(byte_type'(size));
            repeat (size) list_bytes.push_back(byte_type'($urandom));
         end
         if ($urandom_range(3) != 0) begin
            list_bytes.push_back(8'h00);
            repeat ($urandom_range(0, 5)) list_bytes.push_back(8'h00);
         end
         if (shape < 16 && list_bytes.size() > 1) begin
            repeat ($urandom_range(1, list_bytes.size() - 1)) void'(list_bytes.pop_back());
         end else if (shape < 24) begin
            list_bytes.push_back(byte_type'($urandom_range(1, 255)));
         end
      end
      if (list_bytes.size() == 0) list_bytes.push_back(byte_type'($urandom));
      send_list();
   endtask

   initial begin
      int unsigned pct;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         pct = (idle_mode == IDLE_RECEIVER) ? 66 : (idle_mode == IDLE_BOTH) ? 15 : 0;
         rsp_chan.ready = ($urandom_range(99) >= pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tracker.check_result(list_verdict_type'{rsp_chan.list_valid, rsp_chan.attr_found,
                                                 rsp_chan.value_ok, rsp_chan.attr_value,
                                                 rsp_chan.value_len});
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      byte_type    keys[PHASE_COUNT];
      int unsigned phase_bytes;
      int unsigned phase_lists;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.list_byte = '0;
      req_chan.is_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      keys = '{WANTED_KEY_RESET, 8'h00, 8'hFF, byte_type'($urandom_range(2, 254)), 8'h01,
               byte_type'($urandom_range(1, 255))};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_mode = idle_mode_type'(p % 4);
         if (p != 0) write_wanted_key(keys[p]);
         if (p == 0) begin
            list_bytes = '{8'h01};
            send_list();
            list_bytes = '{8'h01, 8'h02, 8'hAA, 8'h55, 8'h01, 8'h00};
            send_list();
            list_bytes = '{8'h01, 8'h01, 8'h80, 8'h00, 8'h07};
            send_list();
            list_bytes = '{8'h01, 8'h02, 8'hFF};
            send_list();
            list_bytes = '{8'h02, 8'h00, 8'h09};
            send_list();
            list_bytes = '{8'h01, 8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           8'hFF, 8'hFF};
            send_list();
         end
         if (p == 4) hold_request = 1'b1;
         phase_bytes = 0;
         phase_lists = 0;
         while (phase_bytes < PHASE_BYTES || phase_lists < PHASE_LISTS) begin
            send_random_list();
            phase_bytes += list_bytes.size();
            phase_lists++;
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/tlvalc_pkg.sv
design/tlvalc_if.sv
design/tlv_attribute_list_checker_core.sv
bench/tlv_attribute_list_checker_core_test.sv
